// File: rtl/fpvd_pkg.sv
// Shared types and constants for the flux pulse varint decoder.
// Used by the channel interfaces and every module of the decoder.
package fpvd_pkg;

	localparam int unsigned TICKS_W  = 32;
	localparam int unsigned NUM_W    = 29;
	localparam int unsigned REVNUM_W = 4;
	localparam int unsigned PPR_W    = 24;
	localparam int unsigned REVS_W   = 5;
	localparam int unsigned PV_W     = 28;
	localparam int unsigned IDX_W    = 2;

	localparam logic [REVS_W-1:0]  MAX_REVOLUTIONS = 5'd16;
	localparam logic [REVS_W-1:0]  REVS_RESET      = 5'd3;
	localparam logic [TICKS_W-1:0] DUMMY_TICKS     = 32'd300;

	// lead byte classes
	localparam logic [7:0] LEAD1_MASK = 8'h80;
	localparam logic [7:0] LEAD2_MASK = 8'hC0;
	localparam logic [7:0] LEAD2_CODE = 8'h80;
	localparam logic [7:0] LEAD3_MASK = 8'hE0;
	localparam logic [7:0] LEAD3_CODE = 8'hC0;
	localparam logic [7:0] LEAD4_MASK = 8'hF0;
	localparam logic [7:0] LEAD4_CODE = 8'hE0;
	localparam logic [7:0] PAY2_MASK  = 8'h3F;
	localparam logic [7:0] PAY3_MASK  = 8'h1F;
	localparam logic [7:0] PAY4_MASK  = 8'h0F;

	// op codes
	localparam logic OP_DATA  = 1'b0;
	localparam logic OP_BEGIN = 1'b1;

	// register indexes
	localparam logic [IDX_W-1:0] REG_PPR       = 2'd0;
	localparam logic [IDX_W-1:0] REG_REV_TICKS = 2'd1;
	localparam logic [IDX_W-1:0] REG_REVS      = 2'd2;

	typedef struct packed {
		logic [PPR_W-1:0]   ppr;
		logic [TICKS_W-1:0] rev_ticks;
		logic [REVS_W-1:0]  eff_revs;
	} cfg_t;

	typedef struct packed {
		logic [TICKS_W-1:0]  pulse_ticks;
		logic [NUM_W-1:0]    pulse_number;
		logic                revolution_end;
		logic [REVNUM_W-1:0] revolution_number;
		logic                end_pulse;
		logic                last;
	} res_t;

	// results of one input word, in order: res_a first
	typedef struct packed {
		logic [1:0] n;
		res_t       res_a;
		res_t       res_b;
	} push_t;

endpackage

// File: rtl/fpvd_ifs.sv
// Valid/ready channel interfaces: coded byte words in, decoded pulse words out.
// Depends on fpvd_pkg for field widths.
interface fpvd_code_if import fpvd_pkg::*; ();
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] data_byte;

	modport source (output valid, output op, output data_byte, input ready);
	modport sink (input valid, input op, input data_byte, output ready);
endinterface

interface fpvd_pulse_if import fpvd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [TICKS_W-1:0]  pulse_ticks;
	logic [NUM_W-1:0]    pulse_number;
	logic                revolution_end;
	logic [REVNUM_W-1:0] revolution_number;
	logic                end_pulse;
	logic                last;

	modport source (output valid, output pulse_ticks, output pulse_number,
		output revolution_end, output revolution_number, output end_pulse,
		output last, input ready);
	modport sink (input valid, input pulse_ticks, input pulse_number,
		input revolution_end, input revolution_number, input end_pulse,
		input last, output ready);
endinterface

// File: rtl/fpvd_regs.sv
// Configuration registers of the decoder with the revolution count clamp.
// Depends on fpvd_pkg.
module fpvd_regs import fpvd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [IDX_W-1:0]   wr_index,
	input  logic [TICKS_W-1:0] wr_data,
	output cfg_t               cfg
);

	logic [PPR_W-1:0]   ppr_q;
	logic [TICKS_W-1:0] rev_ticks_q;
	logic [REVS_W-1:0]  revs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppr_q       <= '0;
			rev_ticks_q <= '0;
			revs_q      <= REVS_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_PPR:       ppr_q       <= wr_data[PPR_W-1:0];
				REG_REV_TICKS: rev_ticks_q <= wr_data;
				REG_REVS:      revs_q      <= wr_data[REVS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.ppr       = ppr_q;
		cfg.rev_ticks = rev_ticks_q;
		if (revs_q == '0)
			cfg.eff_revs = REVS_W'(1);
		else if (revs_q > MAX_REVOLUTIONS)
			cfg.eff_revs = MAX_REVOLUTIONS;
		else
			cfg.eff_revs = revs_q;
	end

endmodule

// File: rtl/fpvd_decode.sv
// Input register, track state and one-pass decode of a coded byte word.
// Produces up to two result words per input word. Depends on fpvd_pkg, fpvd_code_if.
module fpvd_decode import fpvd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	fpvd_code_if.sink    code_ch,
	input  cfg_t         cfg,
	input  logic         room,
	output push_t        push
);

	logic       valid_s1;
	logic       op_s1;
	logic [7:0] byte_s1;
	logic       advance;

	logic [PV_W-1:0]    partial_q,  partial_n;
	logic [1:0]         pend_q,     pend_n;
	logic [PPR_W-1:0]   pir_q,      pir_n;
	logic [REVS_W-1:0]  rc_q,       rc_n;
	logic [TICKS_W-1:0] sum_q,      sum_n;
	logic [TICKS_W-1:0] carry_q,    carry_n;
	logic [NUM_W-1:0]   emitted_q,  emitted_n;
	logic               done_q,     done_n;

	logic               fin;
	logic               emit;
	logic [PV_W-1:0]    fin_val;
	logic [PV_W-1:0]    pv_cat;
	logic [TICKS_W-1:0] ticks;
	logic [TICKS_W-1:0] sum_add;
	logic [PPR_W-1:0]   pir_inc;
	logic [REVS_W-1:0]  rc_inc;
	logic               ends;
	logic               dummy;
	res_t               res_p;
	res_t               res_d;

	assign advance       = valid_s1 && room;
	assign code_ch.ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (code_ch.valid && code_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (code_ch.valid && code_ch.ready) begin
			op_s1   <= code_ch.op;
			byte_s1 <= code_ch.data_byte;
		end
	end

	assign pv_cat  = {partial_q[PV_W-9:0], byte_s1};
	assign pir_inc = pir_q + PPR_W'(1);
	assign rc_inc  = rc_q + REVS_W'(1);
	assign ticks   = TICKS_W'(fin_val) + carry_q;
	assign sum_add = sum_q + (emit ? TICKS_W'(fin_val) : '0);
	assign ends    = pir_inc >= cfg.ppr;
	assign dummy   = fin && ends && (rc_inc >= cfg.eff_revs);

	always_comb begin
		partial_n = partial_q;
		pend_n    = pend_q;
		pir_n     = pir_q;
		rc_n      = rc_q;
		sum_n     = sum_q;
		carry_n   = carry_q;
		emitted_n = emitted_q;
		done_n    = done_q;
		fin       = 1'b0;
		emit      = 1'b0;
		fin_val   = '0;

		if (op_s1 == OP_BEGIN) begin
			partial_n = '0;
			pend_n    = '0;
			pir_n     = '0;
			rc_n      = '0;
			sum_n     = '0;
			carry_n   = '0;
			emitted_n = '0;
			done_n    = 1'b0;
		end else if (!done_q && cfg.ppr != '0) begin
			if (pend_q != 2'd0) begin
				partial_n = pv_cat;
				pend_n    = pend_q - 2'd1;
				if (pend_q == 2'd1) begin
					fin     = 1'b1;
					emit    = 1'b1;
					fin_val = pv_cat;
				end
			end else if ((byte_s1 & LEAD1_MASK) == 8'h00) begin
				fin     = 1'b1;
				emit    = 1'b1;
				fin_val = PV_W'(byte_s1);
			end else if ((byte_s1 & LEAD2_MASK) == LEAD2_CODE) begin
				partial_n = PV_W'(byte_s1 & PAY2_MASK);
				pend_n    = 2'd1;
			end else if ((byte_s1 & LEAD3_MASK) == LEAD3_CODE) begin
				partial_n = PV_W'(byte_s1 & PAY3_MASK);
				pend_n    = 2'd2;
			end else if ((byte_s1 & LEAD4_MASK) == LEAD4_CODE) begin
				partial_n = PV_W'(byte_s1 & PAY4_MASK);
				pend_n    = 2'd3;
			end else begin
				// null pulse: counts, emits nothing
				fin = 1'b1;
			end

			if (fin) begin
				carry_n = '0;
				sum_n   = sum_add;
				pir_n   = pir_inc;
				if (ends) begin
					rc_n    = rc_inc;
					carry_n = cfg.rev_ticks - sum_add;
					sum_n   = '0;
					pir_n   = '0;
					if (dummy)
						done_n = 1'b1;
				end
				emitted_n = emitted_q + NUM_W'(emit) + NUM_W'(dummy);
			end
		end
	end

	always_comb begin
		res_p.pulse_ticks       = ticks;
		res_p.pulse_number      = emitted_q;
		res_p.revolution_end    = ends;
		res_p.revolution_number = rc_q[REVNUM_W-1:0];
		res_p.end_pulse         = 1'b0;
		res_p.last              = !dummy;

		res_d.pulse_ticks       = DUMMY_TICKS;
		res_d.pulse_number      = emitted_q + NUM_W'(emit);
		res_d.revolution_end    = 1'b0;
		res_d.revolution_number = rc_q[REVNUM_W-1:0];
		res_d.end_pulse         = 1'b1;
		res_d.last              = 1'b1;

		push.res_a = emit ? res_p : res_d;
		push.res_b = res_d;
		if (advance)
			push.n = {1'b0, emit} + {1'b0, dummy};
		else
			push.n = 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			pend_q    <= '0;
			pir_q     <= '0;
			rc_q      <= '0;
			sum_q     <= '0;
			carry_q   <= '0;
			emitted_q <= '0;
			done_q    <= 1'b0;
		end else if (advance) begin
			partial_q <= partial_n;
			pend_q    <= pend_n;
			pir_q     <= pir_n;
			rc_q      <= rc_n;
			sum_q     <= sum_n;
			carry_q   <= carry_n;
			emitted_q <= emitted_n;
			done_q    <= done_n;
		end
	end

endmodule

// File: rtl/fpvd_outq.sv
// Four-word result queue: takes up to two a cycle, drives one while ready.
// Depends on fpvd_pkg and fpvd_pulse_if.
module fpvd_outq import fpvd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  push_t         push,
	output logic          room,
	fpvd_pulse_if.source  pulse_ch
);

	res_t       mem [4];
	logic [1:0] wp_q;
	logic [1:0] rp_q;
	logic [2:0] count_q;
	logic       pop;
	res_t       head;

	assign head = mem[rp_q];
	assign pop  = pulse_ch.valid && pulse_ch.ready;
	// two free entries cover the worst case of one input word
	assign room = count_q <= 3'd2;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0)
			mem[wp_q] <= push.res_a;
		if (push.n == 2'd2)
			mem[wp_q + 2'd1] <= push.res_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + push.n;
			if (pop)
				rp_q <= rp_q + 2'd1;
			count_q <= count_q + {1'b0, push.n} - {2'b0, pop};
		end
	end

	assign pulse_ch.valid             = count_q != 3'd0;
	assign pulse_ch.pulse_ticks       = head.pulse_ticks;
	assign pulse_ch.pulse_number      = head.pulse_number;
	assign pulse_ch.revolution_end    = head.revolution_end;
	assign pulse_ch.revolution_number = head.revolution_number;
	assign pulse_ch.end_pulse         = head.end_pulse;
	assign pulse_ch.last              = head.last;

endmodule

// File: rtl/flux_pulse_varint_decoder_core.sv
// Flux pulse varint decoder: prefix-coded byte words in, decoded pulse words out.
// An accepted word is registered, decoded, and its results are queued and offered.
// Throughput: one byte word per cycle; a word that ends the track on a pulse yields
// two results, queued together and driven one at a time. The decode stage holds,
// and input stalls, while more than two result words wait in the four-entry queue.
// Reset (arst_n low) clears track state and the queue; config goes to its defaults.
module flux_pulse_varint_decoder_core import fpvd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	fpvd_code_if.sink          code_ch,
	fpvd_pulse_if.source       pulse_ch,
	input  logic               wr_en,
	input  logic [IDX_W-1:0]   wr_index,
	input  logic [TICKS_W-1:0] wr_data
);

	cfg_t  cfg;
	push_t push;
	logic  room;

	fpvd_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	fpvd_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.code_ch (code_ch),
		.cfg     (cfg),
		.room    (room),
		.push    (push)
	);

	fpvd_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.pulse_ch (pulse_ch)
	);

endmodule
